@@ rtl/pmu_pkg.sv @@
// Package: beat types, sequencer states and arithmetic constants of the polynomial multiplier.
package pmu_pkg;

    localparam int COEFF_W = 16;
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 36;
    localparam int ACC_W   = 38;
    localparam int IDX_W   = 6;
    localparam int OIDX_W  = 5;

    localparam logic SIDE_FIRST  = 1'b0;
    localparam logic SIDE_SECOND = 1'b1;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 38'sd34359738367;
    localparam logic signed [ACC_W-1:0] ACC_MIN = -38'sd34359738368;

    typedef struct packed {
        logic                      operand_side;
        logic signed [COEFF_W-1:0] coeff_value;
        logic                      coeff_last;
    } t_in_beat;

    typedef struct packed {
        logic signed [PROD_W-1:0] product_coeff;
        logic [OIDX_W-1:0]        product_index;
        logic                     product_last;
        logic                     term_overflow;
    } t_out_beat;

    typedef struct packed {
        logic             vld;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] k;
    } t_mac_tag;

    typedef struct packed {
        logic                     en;
        logic [IDX_W-1:0]         addr;
        logic signed [PROD_W-1:0] data;
    } t_prod_wr;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } t_state;

endpackage

@@ rtl/pmu_op_store.sv @@
// Operand coefficient memory: one write port, one registered read port.
module pmu_op_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [AW-1:0]                      i_waddr,
    input  logic signed [pmu_pkg::COEFF_W-1:0] i_wdata,
    input  logic [AW-1:0]                      i_raddr,
    output logic signed [pmu_pkg::COEFF_W-1:0] o_rdata
);

    logic signed [pmu_pkg::COEFF_W-1:0] r_mem [DEPTH];
    logic signed [pmu_pkg::COEFF_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pmu_prod_store.sv @@
// Product coefficient memory: one write port, one registered read port.
module pmu_prod_store #(
    parameter int DEPTH = 31,
    parameter int AW    = 5
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [AW-1:0]                     i_waddr,
    input  logic signed [pmu_pkg::PROD_W-1:0] i_wdata,
    input  logic [AW-1:0]                     i_raddr,
    output logic signed [pmu_pkg::PROD_W-1:0] o_rdata
);

    logic signed [pmu_pkg::PROD_W-1:0] r_mem [DEPTH];
    logic signed [pmu_pkg::PROD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pmu_mac.sv @@
// Shared multiply-accumulate unit: tag align, product register, accumulate and saturate.
module pmu_mac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pmu_pkg::t_mac_tag                  i_tag,
    input  logic signed [pmu_pkg::COEFF_W-1:0] i_a,
    input  logic signed [pmu_pkg::COEFF_W-1:0] i_b,
    output pmu_pkg::t_prod_wr                  o_wr,
    output logic                               o_busy
);

    pmu_pkg::t_mac_tag                r_tag1;
    pmu_pkg::t_mac_tag                r_tag2;
    logic signed [pmu_pkg::MUL_W-1:0] r_prod;
    logic signed [pmu_pkg::ACC_W-1:0] r_acc;
    logic signed [pmu_pkg::ACC_W-1:0] w_base;
    logic signed [pmu_pkg::ACC_W-1:0] w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (r_tag2.vld) begin
            r_acc <= w_sum;
        end
    end

    always_comb begin
        w_base = r_tag2.first ? '0 : r_acc;
        w_sum  = w_base + pmu_pkg::ACC_W'(r_prod);
    end

    always_comb begin
        o_wr.en   = r_tag2.vld && r_tag2.last;
        o_wr.addr = r_tag2.k;
        if (w_sum > pmu_pkg::ACC_MAX) begin
            o_wr.data = pmu_pkg::ACC_MAX[pmu_pkg::PROD_W-1:0];
        end else if (w_sum < pmu_pkg::ACC_MIN) begin
            o_wr.data = pmu_pkg::ACC_MIN[pmu_pkg::PROD_W-1:0];
        end else begin
            o_wr.data = w_sum[pmu_pkg::PROD_W-1:0];
        end
    end

    assign o_busy = r_tag1.vld || r_tag2.vld;

endmodule

@@ rtl/polynomial_multiply_unit.sv @@
// Polynomial multiplier top level: operand load, convolution sequencer and product emit.
// Sequence: the beat completing both operands starts the MAC phase, then a drain phase;
// results then follow one beat per cycle, and busy drops with the last result.
// Throughput: one MAC per cycle on the shared unit; the receiver cannot stall results.
// Synchronous active-low reset clears counts, flags and sequencer; stores need no clear.
module polynomial_multiply_unit #(
    parameter int MAX_TERMS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  pmu_pkg::t_in_beat  i_data,
    output logic               o_strobe,
    output pmu_pkg::t_out_beat o_result
);

    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int PD = 2 * MAX_TERMS - 1;
    localparam int PW = $clog2(PD);
    localparam int SW = pmu_pkg::IDX_W + 1;

    pmu_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt0, n_cnt0, r_cnt1, n_cnt1;
    logic            r_done0, n_done0, r_done1, n_done1;
    logic            r_ovf, n_ovf;
    logic [pmu_pkg::IDX_W-1:0] r_k, n_k, r_i, n_i, r_i_hi, n_i_hi;
    logic            r_first, n_first;
    logic [pmu_pkg::IDX_W-1:0] r_top, n_top, r_n, n_n;
    logic            r_out_vld, n_out_vld;
    logic [pmu_pkg::OIDX_W-1:0] r_out_idx, n_out_idx;
    logic            r_out_last, n_out_last, r_out_ovf, n_out_ovf;

    logic                      w_acc;
    logic                      w_we0, w_we1;
    logic [pmu_pkg::IDX_W-1:0] w_na, w_nb, w_kn, w_klast, w_j;
    logic [SW-1:0]             w_sum;
    pmu_pkg::t_mac_tag         w_tag;
    pmu_pkg::t_prod_wr         w_wr;
    logic                      w_mac_busy;
    logic signed [pmu_pkg::COEFF_W-1:0] w_a, w_b;
    logic signed [pmu_pkg::PROD_W-1:0]  w_prod_rdata;

    assign busy  = (r_state != pmu_pkg::ST_LOAD);
    assign w_acc = start && !busy;

    assign w_na    = pmu_pkg::IDX_W'(r_cnt0);
    assign w_nb    = pmu_pkg::IDX_W'(r_cnt1);
    assign w_sum   = SW'(r_cnt0) + SW'(r_cnt1) - SW'(2);
    assign w_klast = w_sum[pmu_pkg::IDX_W-1:0];
    assign w_kn    = r_k + pmu_pkg::IDX_W'(1);
    assign w_j     = r_k - r_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pmu_pkg::ST_LOAD;
            r_cnt0    <= '0;
            r_cnt1    <= '0;
            r_done0   <= 1'b0;
            r_done1   <= 1'b0;
            r_ovf     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt0    <= n_cnt0;
            r_cnt1    <= n_cnt1;
            r_done0   <= n_done0;
            r_done1   <= n_done1;
            r_ovf     <= n_ovf;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_i        <= n_i;
        r_i_hi     <= n_i_hi;
        r_first    <= n_first;
        r_top      <= n_top;
        r_n        <= n_n;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    always_comb begin
        n_state    = r_state;
        n_cnt0     = r_cnt0;
        n_cnt1     = r_cnt1;
        n_done0    = r_done0;
        n_done1    = r_done1;
        n_ovf      = r_ovf;
        n_k        = r_k;
        n_i        = r_i;
        n_i_hi     = r_i_hi;
        n_first    = r_first;
        n_top      = r_top;
        n_n        = r_n;
        n_out_vld  = 1'b0;
        n_out_idx  = r_out_idx;
        n_out_last = r_out_last;
        n_out_ovf  = r_out_ovf;
        w_we0      = 1'b0;
        w_we1      = 1'b0;
        w_tag      = '0;

        if (w_wr.en && (w_wr.data != '0)) begin
            n_top = w_wr.addr;
        end

        case (r_state)
            pmu_pkg::ST_LOAD: begin
                if (w_acc) begin
                    if (i_data.operand_side == pmu_pkg::SIDE_FIRST) begin
                        if (!r_done0) begin
                            if (r_cnt0 < CW'(MAX_TERMS)) begin
                                w_we0  = 1'b1;
                                n_cnt0 = r_cnt0 + CW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                            if (i_data.coeff_last) begin
                                n_done0 = 1'b1;
                            end
                        end
                    end else begin
                        if (!r_done1) begin
                            if (r_cnt1 < CW'(MAX_TERMS)) begin
                                w_we1  = 1'b1;
                                n_cnt1 = r_cnt1 + CW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                            if (i_data.coeff_last) begin
                                n_done1 = 1'b1;
                            end
                        end
                    end
                    if (n_done0 && n_done1) begin
                        n_state = pmu_pkg::ST_MAC;
                        n_k     = '0;
                        n_i     = '0;
                        n_i_hi  = '0;
                        n_first = 1'b1;
                        n_top   = '0;
                    end
                end
            end
            pmu_pkg::ST_MAC: begin
                w_tag.vld   = 1'b1;
                w_tag.first = r_first;
                w_tag.last  = (r_i == r_i_hi);
                w_tag.k     = r_k;
                n_first     = 1'b0;
                if (r_i == r_i_hi) begin
                    if (r_k == w_klast) begin
                        n_state = pmu_pkg::ST_DRAIN;
                    end else begin
                        n_k     = w_kn;
                        n_first = 1'b1;
                        n_i     = (w_kn >= w_nb) ? (w_kn - w_nb + pmu_pkg::IDX_W'(1)) : '0;
                        n_i_hi  = (w_kn < w_na) ? w_kn : (w_na - pmu_pkg::IDX_W'(1));
                    end
                end else begin
                    n_i = r_i + pmu_pkg::IDX_W'(1);
                end
            end
            pmu_pkg::ST_DRAIN: begin
                if (!w_mac_busy) begin
                    n_state = pmu_pkg::ST_EMIT;
                    n_n     = '0;
                end
            end
            pmu_pkg::ST_EMIT: begin
                n_out_vld  = 1'b1;
                n_out_idx  = r_n[pmu_pkg::OIDX_W-1:0];
                n_out_last = (r_n == r_top);
                n_out_ovf  = r_ovf;
                if (r_n == r_top) begin
                    n_state = pmu_pkg::ST_LOAD;
                    n_cnt0  = '0;
                    n_cnt1  = '0;
                    n_done0 = 1'b0;
                    n_done1 = 1'b0;
                    n_ovf   = 1'b0;
                end else begin
                    n_n = r_n + pmu_pkg::IDX_W'(1);
                end
            end
            default: begin
                n_state = pmu_pkg::ST_LOAD;
            end
        endcase
    end

    pmu_op_store #(.DEPTH(MAX_TERMS), .AW(AW)) u_first (
        .i_clk   (i_clk),
        .i_we    (w_we0),
        .i_waddr (r_cnt0[AW-1:0]),
        .i_wdata (i_data.coeff_value),
        .i_raddr (r_i[AW-1:0]),
        .o_rdata (w_a)
    );

    pmu_op_store #(.DEPTH(MAX_TERMS), .AW(AW)) u_second (
        .i_clk   (i_clk),
        .i_we    (w_we1),
        .i_waddr (r_cnt1[AW-1:0]),
        .i_wdata (i_data.coeff_value),
        .i_raddr (w_j[AW-1:0]),
        .o_rdata (w_b)
    );

    pmu_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_tag),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_wr    (w_wr),
        .o_busy  (w_mac_busy)
    );

    pmu_prod_store #(.DEPTH(PD), .AW(PW)) u_prod (
        .i_clk   (i_clk),
        .i_we    (w_wr.en),
        .i_waddr (w_wr.addr[PW-1:0]),
        .i_wdata (w_wr.data),
        .i_raddr (r_n[PW-1:0]),
        .o_rdata (w_prod_rdata)
    );

    assign o_strobe               = r_out_vld;
    assign o_result.product_coeff = w_prod_rdata;
    assign o_result.product_index = r_out_idx;
    assign o_result.product_last  = r_out_last;
    assign o_result.term_overflow = r_out_ovf;

    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == pmu_pkg::ST_EMIT))
        else $error("result beat outside emit phase");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.product_last) |=> !o_strobe)
        else $error("result beat after last product coefficient");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt0 <= CW'(MAX_TERMS)) && (r_cnt1 <= CW'(MAX_TERMS)))
        else $error("operand count beyond capacity");

    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pmu_pkg::ST_EMIT) |-> (r_n <= r_top))
        else $error("emit index beyond kept length");

endmodule

@@ test/tb_top.sv @@
// Testbench for the polynomial multiplier: directed table, random operand pairs, self-checking.
`timescale 1ns / 1ps

module tb_top;

    localparam int     TERMS      = 16;
    localparam int     PROD_DEPTH = 2 * TERMS - 1;
    localparam int     RAND_BEATS = 430;
    localparam longint COEF_MAX   = 64'sd34359738367;
    localparam longint COEF_MIN   = -64'sd34359738368;

    typedef struct {
        pmu_pkg::t_in_beat  beat;
        bit                 typed;
        pmu_pkg::t_out_beat exp;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               o_strobe;
    pmu_pkg::t_in_beat  i_data;
    pmu_pkg::t_out_beat o_result;

    logic signed [pmu_pkg::COEFF_W-1:0] fst_coef [TERMS];
    logic signed [pmu_pkg::COEFF_W-1:0] snd_coef [TERMS];
    int                 fst_cnt;
    int                 snd_cnt;
    bit                 fst_done;
    bit                 snd_done;
    bit                 term_ovf;
    pmu_pkg::t_out_beat prod_out [PROD_DEPTH];

    pmu_pkg::t_out_beat product_due [$];
    t_dir_row           dir_rows [$];
    bit                 row_typed;
    pmu_pkg::t_out_beat row_exp;

    int errors;
    int products;
    int ovf_products;
    int result_beats;
    int ignored_beats;
    int beats_sent;
    int burst_left;

    polynomial_multiply_unit #(
        .MAX_TERMS(TERMS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_data  (i_data),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int multiply_beat(input pmu_pkg::t_in_beat b);
        longint acc [PROD_DEPTH];
        longint v;
        int     len;
        if (b.operand_side == pmu_pkg::SIDE_FIRST ? fst_done : snd_done) begin
            ignored_beats++;
            return 0;
        end
        if (b.operand_side == pmu_pkg::SIDE_FIRST) begin
            if (fst_cnt < TERMS) begin
                fst_coef[fst_cnt] = b.coeff_value;
                fst_cnt++;
            end else begin
                term_ovf = 1'b1;
            end
            if (b.coeff_last) fst_done = 1'b1;
        end else begin
            if (snd_cnt < TERMS) begin
                snd_coef[snd_cnt] = b.coeff_value;
                snd_cnt++;
            end else begin
                term_ovf = 1'b1;
            end
            if (b.coeff_last) snd_done = 1'b1;
        end
        if (!(fst_done && snd_done)) return 0;

        foreach (acc[k]) acc[k] = 0;
        for (int i = 0; i < fst_cnt; i++)
            for (int j = 0; j < snd_cnt; j++)
                acc[i+j] += longint'(fst_coef[i]) * longint'(snd_coef[j]);
        len = fst_cnt + snd_cnt - 1;
        while (len > 1 && acc[len-1] == 0) len--;
        for (int n = 0; n < len; n++) begin
            v = acc[n];
            if (v > COEF_MAX) v = COEF_MAX;
            if (v < COEF_MIN) v = COEF_MIN;
            prod_out[n].product_coeff = v[pmu_pkg::PROD_W-1:0];
            prod_out[n].product_index = 5'(n);
            prod_out[n].product_last  = (n == len - 1);
            prod_out[n].term_overflow = term_ovf;
        end
        fst_cnt  = 0;
        snd_cnt  = 0;
        fst_done = 1'b0;
        snd_done = 1'b0;
        term_ovf = 1'b0;
        return len;
    endfunction

    function automatic void note_miss(input string what, input longint want, input longint got);
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    endfunction

    task automatic check_result(input pmu_pkg::t_out_beat got);
        pmu_pkg::t_out_beat want;
        result_beats++;
        if (product_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat, expected none, actual coeff %0d index %0d",
                     $time, got.product_coeff, got.product_index);
            return;
        end
        want = product_due.pop_front();
        if (got.product_coeff !== want.product_coeff)
            note_miss("product_coeff", want.product_coeff, got.product_coeff);
        if (got.product_index !== want.product_index)
            note_miss("product_index", want.product_index, got.product_index);
        if (got.product_last !== want.product_last)
            note_miss("product_last", want.product_last, got.product_last);
        if (got.term_overflow !== want.term_overflow)
            note_miss("term_overflow", want.term_overflow, got.term_overflow);
    endtask

    always @(posedge i_clk) begin : mon
        int n;
        if (i_rst_n) begin
            if (o_strobe) check_result(o_result);
            if (start && !busy) begin
                n = multiply_beat(i_data);
                if (n > 0) begin
                    products++;
                    if (prod_out[0].term_overflow) ovf_products++;
                    if (row_typed) begin
                        product_due = {product_due, row_exp};
                    end else begin
                        for (int k = 0; k < n; k++) product_due = {product_due, prod_out[k]};
                    end
                end
            end
        end
    end

    task automatic send_beat(input pmu_pkg::t_in_beat b);
        start  <= 1'b1;
        i_data <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        case ($urandom_range(0, 9))
            0: gap = $urandom_range(10, 30);
            1, 2, 3: gap = 0;
            default: gap = $urandom_range(1, 4);
        endcase
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_products();
        start <= 1'b0;
        @(posedge i_clk);
        while (product_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic void add_row(input logic side,
                                    input logic signed [pmu_pkg::COEFF_W-1:0] c,
                                    input logic last, input bit typed = 1'b0,
                                    input longint exp_coeff = 0);
        t_dir_row r;
        r.beat.operand_side    = side;
        r.beat.coeff_value     = c;
        r.beat.coeff_last      = last;
        r.typed                = typed;
        r.exp.product_coeff    = exp_coeff[pmu_pkg::PROD_W-1:0];
        r.exp.product_index    = '0;
        r.exp.product_last     = 1'b1;
        r.exp.term_overflow    = 1'b0;
        dir_rows = {dir_rows, r};
    endfunction

    function automatic logic signed [pmu_pkg::COEFF_W-1:0] rand_coeff(input int zero_pct);
        if ($urandom_range(0, 99) < zero_pct) return '0;
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($urandom_range(0, 511) - 256);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic int pick_terms();
        case ($urandom_range(0, 19))
            0: return TERMS;
            1: return $urandom_range(TERMS + 1, TERMS + 3);
            2, 3: return $urandom_range(7, TERMS - 1);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    task automatic send_product();
        pmu_pkg::t_in_beat fq [$];
        pmu_pkg::t_in_beat sq [$];
        pmu_pkg::t_in_beat b;
        int                na;
        int                nb;
        int                zero_pct;
        na = pick_terms();
        nb = pick_terms();
        zero_pct = ($urandom_range(0, 5) == 0) ? 70 : 8;
        for (int k = 0; k < na; k++) begin
            b.operand_side = pmu_pkg::SIDE_FIRST;
            b.coeff_value  = rand_coeff(zero_pct);
            b.coeff_last   = (k == na - 1);
            fq = {fq, b};
        end
        for (int k = 0; k < nb; k++) begin
            b.operand_side = pmu_pkg::SIDE_SECOND;
            b.coeff_value  = rand_coeff(zero_pct);
            b.coeff_last   = (k == nb - 1);
            sq = {sq, b};
        end
        while (fq.size() != 0 || sq.size() != 0) begin
            pace();
            if ((fq.size() == 0 || sq.size() == 0) && $urandom_range(0, 5) == 0) begin
                // beat for the operand that is already complete
                b.operand_side = (fq.size() == 0) ? pmu_pkg::SIDE_FIRST : pmu_pkg::SIDE_SECOND;
                b.coeff_value  = 16'($urandom());
                b.coeff_last   = 1'($urandom_range(0, 1));
                send_beat(b);
                continue;
            end
            if (fq.size() == 0 || (sq.size() != 0 && $urandom_range(0, 1) == 1))
                b = sq.pop_front();
            else
                b = fq.pop_front();
            send_beat(b);
            beats_sent++;
        end
    endtask

    initial begin
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_data    = '0;
        row_typed = 1'b0;
        row_exp   = '0;
        fst_cnt   = 0;
        snd_cnt   = 0;
        fst_done  = 1'b0;
        snd_done  = 1'b0;
        term_ovf  = 1'b0;
        errors        = 0;
        products      = 0;
        ovf_products  = 0;
        result_beats  = 0;
        ignored_beats = 0;
        beats_sent    = 0;
        burst_left    = 0;

        add_row(pmu_pkg::SIDE_FIRST,  16'sh8000, 1'b1);
        add_row(pmu_pkg::SIDE_SECOND, 16'sh8000, 1'b1, 1'b1, 64'sd1073741824);
        add_row(pmu_pkg::SIDE_SECOND, 16'sh7fff, 1'b1);
        add_row(pmu_pkg::SIDE_FIRST,  16'sh7fff, 1'b1, 1'b1, 64'sd1073676289);
        add_row(pmu_pkg::SIDE_FIRST,  16'sh8000, 1'b1);
        add_row(pmu_pkg::SIDE_SECOND, 16'sh7fff, 1'b1, 1'b1, -64'sd1073709056);
        add_row(pmu_pkg::SIDE_FIRST,  16'sh0000, 1'b0);
        add_row(pmu_pkg::SIDE_FIRST,  16'sh0000, 1'b1);
        add_row(pmu_pkg::SIDE_FIRST,  16'sh0005, 1'b0);
        add_row(pmu_pkg::SIDE_SECOND, 16'sh0000, 1'b1, 1'b1, 0);
        // (256 + 512x + 0x^2)(256 - 256x + 0x^2): high zeros trimmed
        add_row(pmu_pkg::SIDE_FIRST,  16'sh0100, 1'b0);
        add_row(pmu_pkg::SIDE_SECOND, 16'sh0100, 1'b0);
        add_row(pmu_pkg::SIDE_FIRST,  16'sh0200, 1'b0);
        add_row(pmu_pkg::SIDE_SECOND, 16'shff00, 1'b0);
        add_row(pmu_pkg::SIDE_FIRST,  16'sh0000, 1'b1);
        add_row(pmu_pkg::SIDE_SECOND, 16'sh0000, 1'b1);
        add_row(pmu_pkg::SIDE_SECOND, 16'sh7fff, 1'b1);
        add_row(pmu_pkg::SIDE_SECOND, 16'sh0003, 1'b0);
        add_row(pmu_pkg::SIDE_FIRST,  16'sh8000, 1'b0);
        add_row(pmu_pkg::SIDE_FIRST,  16'sh0001, 1'b0);
        add_row(pmu_pkg::SIDE_FIRST,  16'shffff, 1'b1);
        add_row(pmu_pkg::SIDE_FIRST,  16'sh0000, 1'b1);
        add_row(pmu_pkg::SIDE_SECOND, 16'shabcd, 1'b1, 1'b1, 0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            pace();
            row_typed <= dir_rows[k].typed;
            row_exp   <= dir_rows[k].exp;
            send_beat(dir_rows[k].beat);
        end
        row_typed <= 1'b0;
        drain_products();

        while (beats_sent < RAND_BEATS) begin
            send_product();
            if ($urandom_range(0, 15) == 0) drain_products();
        end
        drain_products();
        repeat (40) @(posedge i_clk);

        $display("Run covered %0d random operand beats plus %0d directed, %0d beats ignored,",
                 beats_sent, dir_rows.size(), ignored_beats);
        $display("%0d products, %0d result beats checked, %0d products with term overflow.",
                 products, result_beats, ovf_products);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/pmu_pkg.sv
rtl/pmu_op_store.sv
rtl/pmu_prod_store.sv
rtl/pmu_mac.sv
rtl/polynomial_multiply_unit.sv
test/tb_top.sv
